[sv/cdsc_pkg.sv]
// Shared types and constants for the countdown stopwatch / clock controller.
// No dependencies; imported by cdsc_buttons and the top level.
package cdsc_pkg;

  // operating modes
  typedef enum logic [1:0] {
    MODE_SW_STOP  = 2'd0,
    MODE_SW_RUN   = 2'd1,
    MODE_CLK_SHOW = 2'd2,
    MODE_CLK_SET  = 2'd3
  } op_mode_e;

  // configuration register indexes
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 11;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SW_START  = 2'd0,
    CFG_SW_FLOOR  = 2'd1,
    CFG_DEB_THR   = 2'd2,
    CFG_BEEP_LEN  = 2'd3
  } cfg_idx_e;

  // field widths
  localparam int unsigned StartW  = 10;
  localparam int unsigned CountW  = 11;
  localparam int unsigned HoldW   = 8;
  localparam int unsigned HourW   = 5;
  localparam int unsigned MinuteW = 6;
  localparam int unsigned TenthW  = 10;

  // register reset values
  localparam logic        [StartW-1:0] StartRst = 10'd250;
  localparam logic signed [CountW-1:0] FloorRst = -11'sd999;
  localparam logic        [HoldW-1:0]  ThrRst   = 8'd25;
  localparam logic        [HoldW-1:0]  BeepRst  = 8'd25;

  // highest usable debounce threshold, so a hold counter can sit one above it
  localparam logic [HoldW-1:0] ThrMax = 8'd254;

  // time base
  localparam logic [TenthW-1:0]  MinuteTenths = 10'd600;
  localparam logic [MinuteW-1:0] HourMinutes  = 6'd60;
  localparam logic [HourW-1:0]   DayHours     = 5'd24;

  // debounced button events of one fast tick
  typedef struct packed {
    logic outer;
    logic inner;
  } press_t;

endpackage

[sv/cdsc_buttons.sv]
// Two-button debouncer with hold counters, synchronized while both are held.
// Depends on cdsc_pkg.
module cdsc_buttons (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       step_i,
  input  logic                       outer_level_i,
  input  logic                       inner_level_i,
  input  logic [cdsc_pkg::HoldW-1:0] thr_i,
  output cdsc_pkg::press_t           press_o
);
  import cdsc_pkg::*;

  logic [HoldW-1:0] thr;
  logic [HoldW-1:0] outer_q, inner_q, outer_d, inner_d;
  logic [HoldW-1:0] outer_base, inner_base, low;

  assign thr = (thr_i > ThrMax) ? ThrMax : thr_i;
  assign low = (outer_q < inner_q) ? outer_q : inner_q;

  always_comb begin
    outer_base = outer_q;
    inner_base = inner_q;
    if (outer_level_i && inner_level_i) begin
      outer_base = low;
      inner_base = low;
    end
  end

  // count up to one above the threshold; the step onto thr+1 is the press
  always_comb begin
    outer_d       = outer_base;
    press_o.outer = 1'b0;
    if (!outer_level_i) begin
      outer_d = '0;
    end else if (outer_base <= thr) begin
      outer_d       = outer_base + 1'b1;
      press_o.outer = (outer_base == thr);
    end
  end

  always_comb begin
    inner_d       = inner_base;
    press_o.inner = 1'b0;
    if (!inner_level_i) begin
      inner_d = '0;
    end else if (inner_base <= thr) begin
      inner_d       = inner_base + 1'b1;
      press_o.inner = (inner_base == thr);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outer_q <= '0;
      inner_q <= '0;
    end else if (step_i) begin
      outer_q <= outer_d;
      inner_q <= inner_d;
    end
  end

  // a counter never climbs past the clamped threshold plus one
  a_outer_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i |=> outer_q <= ThrMax + 8'd1)
    else $error("outer hold counter overran");

  a_sync: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && outer_level_i && inner_level_i) |=> outer_q == inner_q)
    else $error("hold counters not synchronized while both held");

  a_press_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && press_o.outer) |=> outer_q == $past(thr) + 8'd1)
    else $error("outer press without reaching threshold");

endmodule

[sv/countdown_stopwatch_clock_controller.sv]
// Top level: countdown stopwatch, 24-hour clock and mode machine.
// Depends on cdsc_pkg and cdsc_buttons.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-------------------------------------------
//  in      | to block  | in_valid_i/in_ready_o | mode_i, outer_level_i, inner_level_i
//  out     | from block| out_valid_o/out_ready_i| op_mode_o, stopwatch_tenths_o, clock_hours_o,
//          |           |                       | clock_minutes_o, tenths_in_minute_o, buzzer_o
//  cfg     | to block  | cfg_we_i              | cfg_idx_i, cfg_wdata_i
//
// Each word passes an input register, then the logic that updates the state
// registers, which double as the result register; one word per cycle is sustained
// while the output is not stalled, set by the single state update stage.
// Reset loads the configuration defaults and clears all state to its start
// values (clock-set mode, countdown at the start value); no clearing pass.
// An output stall holds the state; the input register still takes one more word.
module countdown_stopwatch_clock_controller (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic                                 mode_i,
  input  logic                                 outer_level_i,
  input  logic                                 inner_level_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [1:0]                           op_mode_o,
  output logic signed [cdsc_pkg::CountW-1:0]   stopwatch_tenths_o,
  output logic [cdsc_pkg::HourW-1:0]           clock_hours_o,
  output logic [cdsc_pkg::MinuteW-1:0]         clock_minutes_o,
  output logic [cdsc_pkg::TenthW-1:0]          tenths_in_minute_o,
  output logic                                 buzzer_o,
  input  logic                                 cfg_we_i,
  input  logic [cdsc_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  logic [cdsc_pkg::CfgDataW-1:0]        cfg_wdata_i
);
  import cdsc_pkg::*;

  // configuration
  logic        [StartW-1:0] start_q;
  logic signed [CountW-1:0] floor_q;
  logic        [HoldW-1:0]  thr_q;
  logic        [HoldW-1:0]  beep_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q    <= StartRst;
      floor_q    <= FloorRst;
      thr_q      <= ThrRst;
      beep_len_q <= BeepRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_SW_START: start_q    <= cfg_wdata_i[StartW-1:0];
        CFG_SW_FLOOR: floor_q    <= cfg_wdata_i;
        CFG_DEB_THR:  thr_q      <= cfg_wdata_i[HoldW-1:0];
        CFG_BEEP_LEN: beep_len_q <= cfg_wdata_i[HoldW-1:0];
        default: ;
      endcase
    end
  end

  // input register
  logic in_valid_q, in_tenth_q, in_outer_q, in_inner_q;
  logic out_valid_q;
  logic advance;

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_tenth_q <= mode_i;
      in_outer_q <= outer_level_i;
      in_inner_q <= inner_level_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // debounce: hold counters only move on a fast tick
  press_t press;
  logic   fast_step;

  assign fast_step = advance && !in_tenth_q;

  cdsc_buttons u_buttons (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (fast_step),
    .outer_level_i (in_outer_q),
    .inner_level_i (in_inner_q),
    .thr_i         (thr_q),
    .press_o       (press)
  );

  // state
  op_mode_e                 mode_q, mode_d;
  logic signed [CountW-1:0] countdown_q, countdown_d;
  logic [HourW-1:0]         hour_q, hour_d;
  logic [MinuteW-1:0]       minute_q, minute_d;
  logic [TenthW-1:0]        tenth_q, tenth_d;
  logic                     beep_q, beep_d;
  logic [HoldW-1:0]         beep_cnt_q, beep_cnt_d;

  logic              above_floor;
  logic              both, outer_only, inner_only;
  logic              minute_wrap;
  logic [TenthW-1:0] tenth_inc;
  logic [HoldW-1:0]  beep_cnt_inc;

  assign above_floor  = countdown_q > floor_q;
  assign both         = press.outer && press.inner;
  assign outer_only   = press.outer && !press.inner;
  assign inner_only   = press.inner && !press.outer;
  assign tenth_inc    = tenth_q + 1'b1;
  assign minute_wrap  = (tenth_inc >= MinuteTenths);
  assign beep_cnt_inc = beep_cnt_q + 1'b1;

  // next mode
  always_comb begin
    mode_d = mode_q;
    if (!in_tenth_q) begin
      if (both) begin
        case (mode_q)
          MODE_SW_STOP:  mode_d = MODE_CLK_SHOW;
          MODE_CLK_SHOW: mode_d = MODE_SW_STOP;
          MODE_CLK_SET:  mode_d = MODE_SW_STOP;
          default:       mode_d = mode_q;
        endcase
      end else if (outer_only) begin
        case (mode_q)
          MODE_SW_STOP: mode_d = above_floor ? MODE_SW_RUN : MODE_SW_STOP;
          MODE_SW_RUN:  mode_d = MODE_SW_STOP;
          default:      mode_d = mode_q;
        endcase
      end else if (inner_only) begin
        case (mode_q)
          MODE_SW_RUN: mode_d = MODE_SW_STOP;
          default:     mode_d = mode_q;
        endcase
      end
    end else begin
      // a run that sits on the floor stops instead of counting
      if (mode_q == MODE_SW_RUN && !above_floor) begin
        mode_d = MODE_SW_STOP;
      end
      // the minute rollover drops out of clock set
      if (minute_wrap && mode_q == MODE_CLK_SET) begin
        mode_d = MODE_CLK_SHOW;
      end
    end
  end

  // countdown, clock and buzzer
  always_comb begin
    countdown_d = countdown_q;
    hour_d      = hour_q;
    minute_d    = minute_q;
    tenth_d     = tenth_q;
    beep_d      = beep_q;
    beep_cnt_d  = beep_cnt_q;
    if (!in_tenth_q) begin
      // reload on both-held from the clock modes, or inner while stopped
      if ((both && (mode_q == MODE_CLK_SHOW || mode_q == MODE_CLK_SET)) ||
          (inner_only && mode_q == MODE_SW_STOP)) begin
        countdown_d = signed'({1'b0, start_q});
      end
      if (outer_only && mode_q == MODE_CLK_SET) begin
        minute_d = (minute_q + 1'b1 >= HourMinutes) ? '0 : minute_q + 1'b1;
      end
      if (inner_only && mode_q == MODE_CLK_SET) begin
        hour_d = (hour_q + 1'b1 >= DayHours) ? '0 : hour_q + 1'b1;
      end
      // buzzer length counts fast ticks only while sounding
      if (beep_q) begin
        beep_cnt_d = beep_cnt_inc;
        if (beep_cnt_inc == beep_len_q) begin
          beep_d = 1'b0;
        end
      end
    end else begin
      if (mode_q == MODE_SW_RUN && above_floor) begin
        countdown_d = countdown_q - 1'b1;
        // sound when the count lands on zero
        if (countdown_q == CountW'(1)) begin
          beep_d     = 1'b1;
          beep_cnt_d = '0;
        end
      end
      if (minute_wrap) begin
        tenth_d = '0;
        if (minute_q + 1'b1 >= HourMinutes) begin
          minute_d = '0;
          hour_d   = (hour_q + 1'b1 >= DayHours) ? '0 : hour_q + 1'b1;
        end else begin
          minute_d = minute_q + 1'b1;
        end
      end else begin
        tenth_d = tenth_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_CLK_SET;
      countdown_q <= signed'({1'b0, StartRst});
      hour_q      <= '0;
      minute_q    <= '0;
      tenth_q     <= '0;
      beep_q      <= 1'b0;
      beep_cnt_q  <= '0;
    end else if (advance) begin
      mode_q      <= mode_d;
      countdown_q <= countdown_d;
      hour_q      <= hour_d;
      minute_q    <= minute_d;
      tenth_q     <= tenth_d;
      beep_q      <= beep_d;
      beep_cnt_q  <= beep_cnt_d;
    end
  end

  // the state registers hold the result of the last word
  assign out_valid_o        = out_valid_q;
  assign op_mode_o          = mode_q;
  assign stopwatch_tenths_o = countdown_q;
  assign clock_hours_o      = hour_q;
  assign clock_minutes_o    = minute_q;
  assign tenths_in_minute_o = tenth_q;
  assign buzzer_o           = beep_q;

  a_clock_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tenth_q < MinuteTenths && minute_q < HourMinutes && hour_q < DayHours)
    else $error("clock counters out of range");

  a_hold_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(mode_q) && $stable(countdown_q) && $stable(tenth_q))
    else $error("state moved without a word");

  a_beep_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(beep_q) |-> $past(advance && in_tenth_q) && countdown_q == '0)
    else $error("buzzer started away from a zero crossing");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> !$past(advance))
    else $error("result replaced before it was taken");

endmodule
